// ----- rtl/iirdf_pkg.sv -----
// iirdf_pkg: shared widths, register indexes and the control struct of the
// direct form I filter. No dependencies; used by iirdf_mac and the top level.
package iirdf_pkg;

  localparam int SAMPLE_W  = 16;   // input and output samples
  localparam int COEF_W    = 32;   // Q4.28 coefficients
  localparam int HIST_W    = 32;   // Q16.16 output history
  localparam int OPND_W    = 32;   // multiplier operand, samples sign-extended
  localparam int PROD_W    = COEF_W + OPND_W;
  localparam int ACC_W     = 52;   // Q.28 accumulator, seven terms cannot overflow
  localparam int FB_SHIFT  = 16;   // Q.44 feedback product down to Q.28
  localparam int H_SHIFT   = 12;   // Q.28 accumulator down to Q16.16
  localparam int CFG_IDX_W = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_1 = 3'd4;

  localparam logic [COEF_W-1:0] FF_COEF_0_RESET = 32'h1000_0000;  // 1.0

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic clear;   // zero the accumulator
    logic issue;   // start a product this cycle
    logic fb;      // product is a feedback term: scale down and subtract
  } mac_ctrl_t;

endpackage

// ----- rtl/iirdf_mac.sv -----
// iirdf_mac: shared multiply-accumulate unit, one tap product per cycle.
// Depends on iirdf_pkg.
module iirdf_mac import iirdf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctrl_t                ctrl,
  input  logic signed [COEF_W-1:0] coef,
  input  logic signed [OPND_W-1:0] opnd,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_scaled;
  logic                     prod_fb;
  logic                     prod_valid;
  logic signed [ACC_W-1:0]  term;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.issue;
    end
    if (ctrl.issue) begin
      prod    <= coef * opnd;
      prod_fb <= ctrl.fb;
    end
  end

  // Feedback product: floor shift from Q.44 to Q.28, then subtract
  assign prod_scaled = prod >>> FB_SHIFT;

  always_comb begin
    if (prod_fb) begin
      term = -$signed(prod_scaled[ACC_W-1:0]);
    end else begin
      term = $signed(prod[ACC_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + term;
    end
  end

endmodule

// ----- rtl/iir_direct_form_filter_top.sv -----
// Direct form I IIR filter, top level: coefficient registers, delay lines,
// sequencer and output register. Depends on iirdf_pkg and iirdf_mac.
//
// Each input transaction carries one signed 16-bit sample x[n]; each output
// transaction returns y[n] rounded and saturated to 16 bits, with clipped set
// when either the Q16.16 history value or the output saturated. The filter
// forms sum b[k]*x[n-k] - sum a[k]*y[n-1-k] over NUM_FEEDFORWARD feedforward
// and NUM_FEEDBACK feedback taps, all on one shared 32x32 multiplier feeding a
// 52-bit accumulator, one tap per cycle. After acceptance a sample keeps the
// block busy through its steps in order: the taps on the multiplier, a drain
// of the last product, a round and saturate into the history, and a round to
// 16 bits into the output register. The block is ready again in the cycle
// after that and takes no new sample before it is through with the last. The
// output register lets a result wait for the consumer while the next sample
// is taken in; the block stalls only if a second result is ready before the
// first one has been taken. Coefficients are Q4.28 and are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while the filter
// is idle, which the block itself does not enforce: index 0..3 are b0..b3,
// 4..6 are a1..a3; writes to taps beyond the built counts or to index 7 are
// dropped. Both delay lines clear at reset, and b0 resets to 1.0.
module iir_direct_form_filter_top import iirdf_pkg::*; #(
  parameter int NUM_FEEDFORWARD = 3,   // 1..4
  parameter int NUM_FEEDBACK    = 2    // 1..3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       clipped,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COEF_W-1:0]          cfg_data
);

  localparam int NUM_TAPS = NUM_FEEDFORWARD + NUM_FEEDBACK;
  localparam int CNT_W    = $clog2(NUM_TAPS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RUN   = 5'b00010,
    S_DRAIN = 5'b00100,
    S_ROUND = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0] cnt;

  // Coefficient registers, built taps only
  logic signed [COEF_W-1:0] ff_coef [NUM_FEEDFORWARD];
  logic signed [COEF_W-1:0] fb_coef [NUM_FEEDBACK];

  // Delay lines
  logic signed [SAMPLE_W-1:0] x_hist [NUM_FEEDFORWARD];
  logic signed [HIST_W-1:0]   y_hist [NUM_FEEDBACK];

  // Work line: coefficient/operand pairs, shifted toward entry 0 per tap
  logic signed [COEF_W-1:0] coef_sh [NUM_TAPS];
  logic signed [OPND_W-1:0] opnd_sh [NUM_TAPS];
  logic                     fb_sh   [NUM_TAPS];

  mac_ctrl_t               mac_ctrl;
  logic signed [ACC_W-1:0] acc;

  logic signed [HIST_W-1:0] h_reg;
  logic                     clip_h;

  logic                        in_acc;
  logic                        out_load;
  logic [ACC_W-1:0]            acc_rnd;
  logic [ACC_W-H_SHIFT-1:0]    h_wide;
  logic                        h_sat;
  logic signed [HIST_W-1:0]    h_next;
  logic [HIST_W:0]             y_rnd;
  logic [SAMPLE_W:0]           y_wide;
  logic                        y_sat;
  logic signed [SAMPLE_W-1:0]  y_next;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state == S_FIN) && (!out_valid || out_ready);

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_RUN;
      S_RUN:   if (cnt == CNT_W'(1)) state_next = S_DRAIN;
      S_DRAIN: state_next = S_ROUND;
      S_ROUND: state_next = S_FIN;
      S_FIN:   if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        cnt <= CNT_W'(NUM_TAPS);
      end else if (state == S_RUN) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  // Coefficient writes; indexes of unbuilt taps fall through and are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_FEEDFORWARD; k++) begin
        ff_coef[k] <= (k == 0) ? FF_COEF_0_RESET : '0;
      end
      for (int j = 0; j < NUM_FEEDBACK; j++) begin
        fb_coef[j] <= '0;
      end
    end else if (cfg_we) begin
      for (int k = 0; k < NUM_FEEDFORWARD; k++) begin
        if (cfg_index == REG_FF_COEF_0 + CFG_IDX_W'(k)) ff_coef[k] <= cfg_data;
      end
      for (int j = 0; j < NUM_FEEDBACK; j++) begin
        if (cfg_index == REG_FB_COEF_1 + CFG_IDX_W'(j)) fb_coef[j] <= cfg_data;
      end
    end
  end

  // Feedforward delay line: advance on each accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_FEEDFORWARD; k++) x_hist[k] <= '0;
    end else if (in_acc) begin
      x_hist[0] <= sample_in;
      for (int k = 1; k < NUM_FEEDFORWARD; k++) x_hist[k] <= x_hist[k-1];
    end
  end

  // Feedback delay line: advance once the saturated history value is known
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NUM_FEEDBACK; j++) y_hist[j] <= '0;
    end else if (state == S_ROUND) begin
      y_hist[0] <= h_next;
      for (int j = 1; j < NUM_FEEDBACK; j++) y_hist[j] <= y_hist[j-1];
    end
  end

  // Load the work line at acceptance, then advance one tap per cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      coef_sh[0] <= ff_coef[0];
      opnd_sh[0] <= OPND_W'(sample_in);
      fb_sh[0]   <= 1'b0;
      for (int k = 1; k < NUM_FEEDFORWARD; k++) begin
        coef_sh[k] <= ff_coef[k];
        opnd_sh[k] <= OPND_W'(x_hist[k-1]);
        fb_sh[k]   <= 1'b0;
      end
      for (int j = 0; j < NUM_FEEDBACK; j++) begin
        coef_sh[NUM_FEEDFORWARD+j] <= fb_coef[j];
        opnd_sh[NUM_FEEDFORWARD+j] <= y_hist[j];
        fb_sh[NUM_FEEDFORWARD+j]   <= 1'b1;
      end
    end else if (state == S_RUN) begin
      for (int k = 0; k < NUM_TAPS - 1; k++) begin
        coef_sh[k] <= coef_sh[k+1];
        opnd_sh[k] <= opnd_sh[k+1];
        fb_sh[k]   <= fb_sh[k+1];
      end
    end
  end

  always_comb begin
    mac_ctrl.clear = in_acc;
    mac_ctrl.issue = (state == S_RUN);
    mac_ctrl.fb    = fb_sh[0];
  end

  iirdf_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .coef (coef_sh[0]),
    .opnd (opnd_sh[0]),
    .acc  (acc)
  );

  // Round half up from Q.28 to Q16.16 and saturate to 32 bits
  always_comb begin
    acc_rnd = acc + (ACC_W'(1) << (H_SHIFT - 1));
    h_wide  = acc_rnd[ACC_W-1:H_SHIFT];
    h_sat   = !((&h_wide[ACC_W-H_SHIFT-1:HIST_W-1]) || !(|h_wide[ACC_W-H_SHIFT-1:HIST_W-1]));
    if (h_sat) begin
      h_next = h_wide[ACC_W-H_SHIFT-1] ? {1'b1, {(HIST_W-1){1'b0}}}
                                       : {1'b0, {(HIST_W-1){1'b1}}};
    end else begin
      h_next = h_wide[HIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ROUND) begin
      h_reg  <= h_next;
      clip_h <= h_sat;
    end
  end

  // Round half up from Q16.16 to an integer and saturate to 16 bits
  always_comb begin
    y_rnd  = {h_reg[HIST_W-1], h_reg} + ((HIST_W+1)'(1) << (HIST_W/2 - 1));
    y_wide = y_rnd[HIST_W:HIST_W/2];
    y_sat  = (y_wide[SAMPLE_W] != y_wide[SAMPLE_W-1]);
    if (y_sat) begin
      y_next = y_wide[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      y_next = y_wide[SAMPLE_W-1:0];
    end
  end

  // Output register: hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      sample_out <= y_next;
      clipped    <= clip_h || y_sat;
    end
  end

  // Accepted sample starts the tap sweep with a full count
  a_start_run: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == S_RUN) && (cnt == CNT_W'(NUM_TAPS)))
    else $error("tap sweep did not start after an accepted sample");

  // The sweep never runs with an exhausted tap count
  a_cnt_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (cnt != '0))
    else $error("tap sweep running with zero taps left");

  // A finished result reaches the output register
  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && (state == S_IDLE))
    else $error("finished result not presented");

  // The multiplier is idle whenever a new sample may enter
  a_mac_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !mac_ctrl.issue)
    else $error("multiplier issued outside the tap sweep");

endmodule
